>>> rtl/core/imq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imq_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DECREASE = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int KEY_W = 32;
    localparam int VTX_W = 8;
    localparam int CNT_W = 9;

    typedef struct packed {
        logic [1:0]       status;
        logic [VTX_W-1:0] min_vertex;
        logic [KEY_W-1:0] min_key;
        logic [CNT_W-1:0] entry_count;
    } imq_result_t;

endpackage
`default_nettype wire

>>> rtl/core/indexed_min_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | direction | handshake          | words carried
// s_       | in        | s_valid / s_ready  | op, vertex, key
// m_       | out       | m_valid / m_ready  | status, min_vertex, min_key, entry_count
// cfg      | in        | cfg_we             | capacity_limit
//
// One word is worked at a time. An insert climbs the heap level by level through S_UPRD and
// S_UPCMP, a decrease first checks its stored key in S_DELRD and then climbs alike, and a delete-min
// descends level by level through S_DNRD, S_DNCMP and S_DNW2; the memories' registered reads set these steps.
// After reset the position map is cleared one entry a cycle; no word is accepted meanwhile. A
// stalled m_ready holds the result register; the next word is accepted while it waits, though
// not started until it leaves.
module indexed_min_priority_queue_core
    import imq_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int VERTEX_COUNT = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_op,
    input  wire logic [VTX_W-1:0]  s_vertex,
    input  wire logic [KEY_W-1:0]  s_key,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [1:0]        m_status,
    output logic      [VTX_W-1:0]  m_min_vertex,
    output logic      [KEY_W-1:0]  m_min_key,
    output logic      [CNT_W-1:0]  m_entry_count
);
    // Slot addresses run 1..CAPACITY, so the map holds values up to CAPACITY.
    localparam int HAW = $clog2(CAPACITY + 1);
    localparam int PAW = $clog2(VERTEX_COUNT);
    localparam int SW  = HAW;
    localparam int EW  = KEY_W + VTX_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_UPRD  = 4'd4;
    localparam logic [3:0] S_UPCMP = 4'd5;
    localparam logic [3:0] S_UPW2  = 4'd6;
    localparam logic [3:0] S_DNRD  = 4'd7;
    localparam logic [3:0] S_DNCMP = 4'd8;
    localparam logic [3:0] S_DNW2  = 4'd9;
    localparam logic [3:0] S_DNFIN = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_DELRD = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cap_reg;
    logic [SW-1:0]    size_reg, size_next;
    logic [PAW:0]     clr_reg, clr_next;

    // Accepted word held here until its result is written.
    logic             in_full_reg;
    logic [1:0]       op_reg;
    logic [VTX_W-1:0] vtx_reg;
    logic [KEY_W-1:0] key_reg;

    // Moving entry and its slot during a sift.
    logic [SW-1:0]    pos_reg, pos_next;
    logic [EW-1:0]    ent_reg, ent_next;
    logic [SW-1:0]    oth_reg, oth_next;
    logic [EW-1:0]    oent_reg, oent_next;
    logic [VTX_W-1:0] rmv_reg, rmv_next;
    logic [KEY_W-1:0] rmk_reg, rmk_next;
    logic [1:0]       st_reg, st_next;

    logic             out_valid_reg;
    imq_result_t      out_reg;

    // Memory ports.
    logic             h_we;
    logic [SW-1:0]    h_wa, h_ra, h_rb;
    logic [EW-1:0]    h_wd, h_qa, h_qb;
    logic             p_we;
    logic [PAW-1:0]   p_wa, p_ra;
    logic [SW-1:0]    p_wd, p_q;

    imq_heap_ram #(.AW(SW)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .raddr_a(h_ra), .raddr_b(h_rb), .rdata_a(h_qa), .rdata_b(h_qb)
    );

    imq_pos_ram #(.AW(PAW), .DW(SW)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .raddr(p_ra), .rdata(p_q)
    );

    logic [SW:0]      limit;
    logic             vtx_ok;
    logic [SW-1:0]    lchild, rchild;
    logic [KEY_W-1:0] ekey;

    assign limit   = (32'(cap_reg) < 32'(CAPACITY)) ? (SW+1)'(cap_reg) : (SW+1)'(CAPACITY);
    assign vtx_ok  = 32'(vtx_reg) < 32'(VERTEX_COUNT);
    assign lchild  = SW'({pos_reg, 1'b0});
    assign rchild  = SW'({pos_reg, 1'b1});
    assign ekey    = ent_reg[EW-1:VTX_W];
    assign s_ready = !in_full_reg && state_reg != S_CLEAR;

    always_comb begin
        state_next = state_reg;
        size_next  = size_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        ent_next   = ent_reg;
        oth_next   = oth_reg;
        oent_next  = oent_reg;
        rmv_next   = rmv_reg;
        rmk_next   = rmk_reg;
        st_next    = st_reg;
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0; h_rb = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0;
        p_ra = PAW'(vtx_reg);
        case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1;
                p_wa = clr_reg[PAW-1:0];
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == VERTEX_COUNT - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_full_reg && !out_valid_reg) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // Map read issued on p_ra; also fetch root and last slot.
                h_ra = SW'(1);
                h_rb = size_reg;
                state_next = S_START;
                st_next  = ST_OK;
                rmv_next = '0;
                rmk_next = '0;
            end
            S_START: begin
                case (op_reg)
                    OP_INSERT: begin
                        if ((SW+1)'(size_reg) >= limit) begin
                            st_next = ST_FULL; state_next = S_DONE;
                        end else if (!vtx_ok || p_q != '0) begin
                            st_next = ST_BAD; state_next = S_DONE;
                        end else begin
                            size_next = size_reg + 1'b1;
                            pos_next  = size_reg + 1'b1;
                            ent_next  = {key_reg, vtx_reg};
                            state_next = S_UPRD;
                        end
                    end
                    OP_DECREASE: begin
                        if (!vtx_ok || p_q == '0 || p_q > size_reg) begin
                            st_next = ST_BAD; state_next = S_DONE;
                        end else begin
                            h_ra = p_q;
                            pos_next = p_q;
                            ent_next = {key_reg, vtx_reg};
                            state_next = S_DELRD;
                        end
                    end
                    OP_DELETE: begin
                        if (size_reg == '0) begin
                            st_next = ST_EMPTY; state_next = S_DONE;
                        end else begin
                            rmk_next = h_qa[EW-1:VTX_W];
                            rmv_next = h_qa[VTX_W-1:0];
                            ent_next = h_qb;
                            pos_next = SW'(1);
                            size_next = size_reg - 1'b1;
                            state_next = S_DNRD;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DELRD: begin
                // Decrease-key: check the stored key before sifting.
                if (key_reg >= h_qa[EW-1:VTX_W]) begin
                    st_next = ST_BAD; state_next = S_DONE;
                end else begin
                    state_next = S_UPRD;
                end
            end
            S_UPRD: begin
                h_ra = pos_reg >> 1;
                state_next = S_UPCMP;
            end
            S_UPCMP: begin
                if (pos_reg > SW'(1) && ekey < h_qa[EW-1:VTX_W]) begin
                    // Parent moves down into the current slot.
                    h_we = 1'b1; h_wa = pos_reg; h_wd = h_qa;
                    p_we = 1'b1; p_wa = PAW'(h_qa[VTX_W-1:0]); p_wd = pos_reg;
                    pos_next = pos_reg >> 1;
                    state_next = S_UPRD;
                end else begin
                    h_we = 1'b1; h_wa = pos_reg; h_wd = ent_reg;
                    state_next = S_UPW2;
                end
            end
            S_UPW2: begin
                p_we = 1'b1; p_wa = PAW'(ent_reg[VTX_W-1:0]); p_wd = pos_reg;
                state_next = S_DONE;
            end
            S_DNRD: begin
                h_ra = lchild;
                h_rb = rchild;
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                oth_next = pos_reg;
                if ((SW+1)'(lchild) <= (SW+1)'(size_reg) && 32'(pos_reg) <= CAPACITY/2
                    && h_qa[EW-1:VTX_W] < ekey
                    && !((SW+1)'(rchild) <= (SW+1)'(size_reg)
                         && h_qb[EW-1:VTX_W] < h_qa[EW-1:VTX_W])) begin
                    oent_next = h_qa; oth_next = lchild;
                end else if ((SW+1)'(rchild) <= (SW+1)'(size_reg)
                             && 32'(pos_reg) <= CAPACITY/2
                             && h_qb[EW-1:VTX_W] < ekey) begin
                    oent_next = h_qb; oth_next = rchild;
                end
                state_next = S_DNW2;
            end
            S_DNW2: begin
                if (oth_reg == pos_reg) begin
                    h_we = 1'b1; h_wa = pos_reg; h_wd = ent_reg;
                    state_next = S_DNFIN;
                end else begin
                    // Winning child moves up.
                    h_we = 1'b1; h_wa = pos_reg; h_wd = oent_reg;
                    p_we = 1'b1; p_wa = PAW'(oent_reg[VTX_W-1:0]); p_wd = pos_reg;
                    pos_next = oth_reg;
                    state_next = S_DNRD;
                end
            end
            S_DNFIN: begin
                if (size_reg != '0) begin
                    p_we = 1'b1; p_wa = PAW'(ent_reg[VTX_W-1:0]); p_wd = pos_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // Removed vertex leaves the map last, as it may equal the mover.
                if (op_reg == OP_DELETE && st_reg == ST_OK) begin
                    p_we = 1'b1; p_wa = PAW'(rmv_reg); p_wd = '0;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            size_reg      <= '0;
            cap_reg       <= CNT_W'(256);
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            size_reg  <= size_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_full_reg <= 1'b1;
            end else if (state_reg == S_DONE) begin
                in_full_reg <= 1'b0;
            end
            if (state_reg == S_DONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        ent_reg  <= ent_next;
        oth_reg  <= oth_next;
        oent_reg <= oent_next;
        rmv_reg  <= rmv_next;
        rmk_reg  <= rmk_next;
        st_reg   <= st_next;
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            vtx_reg <= s_vertex;
            key_reg <= s_key;
        end
        if (state_reg == S_DONE) begin
            out_reg.status      <= st_reg;
            out_reg.min_vertex  <= rmv_reg;
            out_reg.min_key     <= rmk_reg;
            out_reg.entry_count <= CNT_W'(size_reg);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_min_vertex  = out_reg.min_vertex;
    assign m_min_key     = out_reg.min_key;
    assign m_entry_count = out_reg.entry_count;

    // The heap never grows beyond its capacity.
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(size_reg) <= CAPACITY)
        else $error("heap size beyond capacity");

    // A word is only started once the previous result has been taken.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOK) |-> $past(!out_valid_reg))
        else $error("work started over a pending result");

    // The heap size only changes in the start step.
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_START) |=> $stable(size_reg))
        else $error("heap size changed outside the start step");
endmodule
`default_nettype wire

>>> rtl/core/imq_heap_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Heap slot store: one write port, two registered read ports.
module imq_heap_ram
    import imq_pkg::*;
#(
    parameter int AW = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [KEY_W+VTX_W-1:0] wdata,
    input  wire logic [AW-1:0]          raddr_a,
    input  wire logic [AW-1:0]          raddr_b,
    output logic      [KEY_W+VTX_W-1:0] rdata_a,
    output logic      [KEY_W+VTX_W-1:0] rdata_b
);
    logic [KEY_W+VTX_W-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

>>> rtl/core/imq_pos_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Vertex position map, with no reset of its own; the core's clearing pass after reset zeroes every entry.
module imq_pos_ram #(
    parameter int AW = 8,
    parameter int DW = 9
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sim/indexed_min_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the indexed min-heap core. Directed words, then random operations, are fed
// through the s_ channel, a behavioural heap inside a small scoreboard class
// predicts every result word, and the m_ channel is compared field by field.
module indexed_min_priority_queue_core_tb;
    import imq_pkg::*;

    // The operation code that leaves the heap untouched; the core still answers it with ST_OK.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Behavioural copy of the heap; it predicts the result word of each
    // accepted operation and keeps the predictions in arrival order.
    class heap_scoreboard;
        logic [KEY_W-1:0] slot_key [1:256];
        logic [VTX_W-1:0] slot_vtx [1:256];
        int               vtx_slot [0:255];
        int               occupancy;
        int               cap_limit;
        imq_result_t      pending_results [$];
        int               mismatches;

        function void clear();
            foreach (vtx_slot[i]) vtx_slot[i] = 0;
            occupancy = 0;
            cap_limit = 256;
            mismatches = 0;
        endfunction

        function void swap_entries(int a, int b);
            logic [KEY_W-1:0] k;
            logic [VTX_W-1:0] v;
            k = slot_key[a];
            v = slot_vtx[a];
            slot_key[a] = slot_key[b];
            slot_vtx[a] = slot_vtx[b];
            slot_key[b] = k;
            slot_vtx[b] = v;
            vtx_slot[slot_vtx[a]] = a;
            vtx_slot[slot_vtx[b]] = b;
        endfunction

        function void climb(int pos);
            while (pos > 1 && slot_key[pos] < slot_key[pos / 2]) begin
                swap_entries(pos, pos / 2);
                pos = pos / 2;
            end
        endfunction

        function void descend(int pos);
            int lc;
            int best;
            forever begin
                lc = 2 * pos;
                best = pos;
                if (lc <= occupancy && slot_key[lc] < slot_key[best]) best = lc;
                if (lc + 1 <= occupancy && slot_key[lc + 1] < slot_key[best]) best = lc + 1;
                if (best == pos) return;
                swap_entries(pos, best);
                pos = best;
            end
        endfunction

        function void note_word(logic [1:0] op, logic [VTX_W-1:0] vtx, logic [KEY_W-1:0] key);
            imq_result_t r;
            int pos;
            int limit;
            r = '0;
            r.status = ST_OK;
            // The register may exceed the number of slots; the slots win.
            limit = (cap_limit < 256) ? cap_limit : 256;
            if (op == OP_INSERT) begin
                if (occupancy >= limit) begin
                    r.status = ST_FULL;
                end else if (vtx_slot[vtx] != 0) begin
                    r.status = ST_BAD;
                end else begin
                    occupancy++;
                    slot_key[occupancy] = key;
                    slot_vtx[occupancy] = vtx;
                    vtx_slot[vtx] = occupancy;
                    climb(occupancy);
                end
            end else if (op == OP_DECREASE) begin
                pos = vtx_slot[vtx];
                if (pos < 1 || pos > occupancy || key >= slot_key[pos]) begin
                    r.status = ST_BAD;
                end else begin
                    slot_key[pos] = key;
                    climb(pos);
                end
            end else if (op == OP_DELETE) begin
                if (occupancy == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.min_vertex = slot_vtx[1];
                    r.min_key = slot_key[1];
                    slot_key[1] = slot_key[occupancy];
                    slot_vtx[1] = slot_vtx[occupancy];
                    occupancy--;
                    vtx_slot[slot_vtx[1]] = 1;
                    descend(1);
                    vtx_slot[r.min_vertex] = 0;
                end
            end
            r.entry_count = occupancy[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_word(imq_result_t got);
            imq_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.min_vertex !== want.min_vertex ||
                got.min_key !== want.min_key || got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st=%0d v=%0d k=%h n=%0d, ",
                              "got st=%0d v=%0d k=%h n=%0d"},
                             want.status, want.min_vertex, want.min_key, want.entry_count,
                             got.status, got.min_vertex, got.min_key, got.entry_count);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_op = OP_INSERT;
    logic [VTX_W-1:0] s_vertex = '0;
    logic [KEY_W-1:0] s_key = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_status;
    logic [VTX_W-1:0] m_min_vertex;
    logic [KEY_W-1:0] m_min_key;
    logic [CNT_W-1:0] m_entry_count;

    heap_scoreboard   board = new();
    bit               idling_on = 1'b1;
    // Cycles left in the current result-side stall.
    int               stall_left = 0;
    // Vertices known to be in the heap, used to aim decreases at live entries.
    int               live_vertices [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    indexed_min_priority_queue_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_vertex(s_vertex), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_min_vertex(m_min_vertex),
        .m_min_key(m_min_key), .m_entry_count(m_entry_count)
    );

    // Offers one word, holding it steady until it is accepted; a random gap
    // may come first while idling is enabled. Valid stays high after the
    // accepting edge so that the next word follows at once; drain drops it.
    task automatic send_word(logic [1:0] op, logic [VTX_W-1:0] vtx, logic [KEY_W-1:0] key);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_vertex <= vtx;
        s_key <= key;
        do @(posedge aclk); while (!s_ready);
        board.note_word(op, vtx, key);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_capacity(int lim);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= lim[CNT_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.cap_limit = int'(lim[CNT_W-1:0]);
    endtask

    // A random key, often drawn from a narrow band so that ties arise.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int words);
        int sel;
        int pick;
        logic [VTX_W-1:0] vtx;
        repeat (words) begin
            sel = $urandom_range(0, 99);
            live_vertices.delete();
            for (int i = 0; i < 256; i++)
                if (board.vtx_slot[i] != 0) live_vertices.push_back(i);
            vtx = VTX_W'($urandom_range(0, 255));
            if (sel < 40) begin
                send_word(OP_INSERT, vtx, pick_key());
            end else if (sel < 70 && live_vertices.size() != 0) begin
                pick = live_vertices[$urandom_range(0, live_vertices.size() - 1)];
                vtx = pick[VTX_W-1:0];
                // Mostly a genuine decrease, sometimes equal or larger.
                if ($urandom_range(0, 4) != 0 && board.slot_key[board.vtx_slot[pick]] != 0)
                    send_word(OP_DECREASE, vtx,
                              $urandom_range(0, board.slot_key[board.vtx_slot[pick]] - 1));
                else
                    send_word(OP_DECREASE, vtx, board.slot_key[board.vtx_slot[pick]] +
                              $urandom_range(0, 1));
            end else if (sel < 74) begin
                send_word(OP_DECREASE, vtx, pick_key());
            end else if (sel < 97) begin
                send_word(OP_DELETE, vtx, $urandom());
            end else begin
                send_word(OP_SPARE, vtx, $urandom());
            end
        end
    endtask

    // Result side: accepts words and stalls in random bursts while idling is enabled.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word('{m_status, m_min_vertex, m_min_key, m_entry_count});
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        board.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty delete, extremes, ties, duplicates, bad decreases, the spare code, capacity limits.
        send_word(OP_DELETE, 8'd0, 32'd0);
        send_word(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 8'd0, 32'd0);
        send_word(OP_INSERT, 8'd7, 32'd5);
        send_word(OP_INSERT, 8'd8, 32'd5);
        send_word(OP_INSERT, 8'd7, 32'd1);
        send_word(OP_DECREASE, 8'd9, 32'd0);
        send_word(OP_DECREASE, 8'd8, 32'd5);
        send_word(OP_DECREASE, 8'd8, 32'd6);
        send_word(OP_DECREASE, 8'd255, 32'd5);
        send_word(OP_DECREASE, 8'd255, 32'd0);
        send_word(OP_SPARE, 8'hAA, 32'h5555_AAAA);
        repeat (6) send_word(OP_DELETE, 8'd0, 32'd0);
        set_capacity(1);
        send_word(OP_INSERT, 8'd3, 32'd9);
        send_word(OP_INSERT, 8'd4, 32'd2);
        send_word(OP_DELETE, 8'd0, 32'd0);
        set_capacity(0);
        send_word(OP_INSERT, 8'd3, 32'd9);

        set_capacity(256);
        random_phase(600);
        set_capacity(5);
        random_phase(300);
        set_capacity(300);
        random_phase(300);
        set_capacity(256);
        random_phase(400);
        idling_on = 1'b0;
        random_phase(200);
        drain();
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/imq_pkg.sv
rtl/core/imq_heap_ram.sv
rtl/core/imq_pos_ram.sv
rtl/core/indexed_min_priority_queue_core.sv
sim/indexed_min_priority_queue_core_tb.sv
